>>> src/bq_pkg.sv
// bq_pkg: shared constants, register codes, operation struct and saturation
// helpers for the biquad filter datapath; no dependencies
package bq_pkg;

   // sample and coefficient formats
   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 28;
   localparam int COEF_BITS      = 32;
   localparam int STATE_BITS     = 32;
   localparam int NUM_COEFS      = 5;
   localparam int INDEX_BITS     = 3;

   // full product, rounded product and accumulator widths
   localparam int PROD_BITS = 2 * COEF_BITS;
   localparam int RND_BITS  = PROD_BITS - COEF_FRAC_BITS;
   localparam int ACC_BITS  = RND_BITS + 2;

   // configuration register indexes
   localparam logic [INDEX_BITS-1:0] REG_B0 = 3'd0;
   localparam logic [INDEX_BITS-1:0] REG_B1 = 3'd1;
   localparam logic [INDEX_BITS-1:0] REG_B2 = 3'd2;
   localparam logic [INDEX_BITS-1:0] REG_A1 = 3'd3;
   localparam logic [INDEX_BITS-1:0] REG_A2 = 3'd4;

   // control of one multiply-accumulate step
   typedef struct packed {
      logic issue;   // a product enters the unit
      logic first;   // start from the init value instead of the accumulator
      logic negate;  // subtract the rounded product
   } mac_op_type;

   // clamp the accumulator to the state width
   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [ACC_BITS-1:0] value
   );
      logic [ACC_BITS-STATE_BITS:0] top;
      top = value[ACC_BITS-1:STATE_BITS-1];
      if ((&top) || !(|top)) begin
         return value[STATE_BITS-1:0];
      end
      return value[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                               : {1'b0, {(STATE_BITS-1){1'b1}}};
   endfunction

   // clamp the accumulator to the sample width
   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [ACC_BITS-1:0] value
   );
      logic [ACC_BITS-SAMPLE_BITS:0] top;
      top = value[ACC_BITS-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         return value[SAMPLE_BITS-1:0];
      end
      return value[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                               : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   endfunction

endpackage

>>> src/bq_mac.sv
// bq_mac: shared multiply-accumulate unit, registered product then rounded
// accumulate; depends on bq_pkg
module bq_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bq_pkg::mac_op_type                    op,
   input  logic signed [bq_pkg::COEF_BITS-1:0]   coef,
   input  logic signed [bq_pkg::STATE_BITS-1:0]  data,
   input  logic signed [bq_pkg::ACC_BITS-1:0]    init,
   output logic signed [bq_pkg::ACC_BITS-1:0]    acc
);

   bq_pkg::mac_op_type                     op_ff;
   logic signed [bq_pkg::PROD_BITS-1:0]    prod_ff, prod_in;
   logic signed [bq_pkg::ACC_BITS-1:0]     init_ff;
   logic signed [bq_pkg::ACC_BITS-1:0]     acc_ff, acc_in;
   logic signed [bq_pkg::ACC_BITS-1:0]     base;
   logic signed [bq_pkg::ACC_BITS-1:0]     term;

   // stage one: full-precision product
   assign prod_in = bq_pkg::PROD_BITS'(coef) * bq_pkg::PROD_BITS'(data);

   // stage two: round half up, then add or subtract
   always_comb begin
      term = bq_pkg::ACC_BITS'($signed(prod_ff[bq_pkg::PROD_BITS-1:bq_pkg::COEF_FRAC_BITS]))
           + bq_pkg::ACC_BITS'({1'b0, prod_ff[bq_pkg::COEF_FRAC_BITS-1]});
      base = op_ff.first ? init_ff : acc_ff;
      if (!op_ff.issue) begin
         acc_in = acc_ff;
      end else if (op_ff.negate) begin
         acc_in = base - term;
      end else begin
         acc_in = base + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0;
      end else begin
         op_ff <= op;
      end
      prod_ff <= prod_in;
      init_ff <= init;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> src/biquad_iir_filter.sv
// biquad_iir_filter: direct form II biquad with five Q3.28 coefficients
// The five products go in turn through the single 32x32 multiplier and its rounding
// accumulator. A new request is taken only in the idle state, so each sample retires before
// the next one is accepted, and retiring waits while an earlier response is held.
// Synchronous active-high reset clears coefficients and both delays to zero.
// Depends on bq_pkg and bq_mac.
module biquad_iir_filter (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [bq_pkg::SAMPLE_BITS-1:0]  req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bq_pkg::SAMPLE_BITS-1:0]  rsp_sample_out,
   input  logic                                   csr_write_en,
   input  logic [bq_pkg::INDEX_BITS-1:0]          csr_index,
   input  logic [bq_pkg::COEF_BITS-1:0]           csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_A1, S_A2, S_W, S_B0, S_B1, S_B2, S_Y, S_OUT
   } state_type;

   state_type                               state_ff;
   logic signed [bq_pkg::COEF_BITS-1:0]     coef_ff [bq_pkg::NUM_COEFS];
   logic signed [bq_pkg::STATE_BITS-1:0]    delay_one_ff, delay_two_ff;
   logic signed [bq_pkg::STATE_BITS-1:0]    w_ff;
   logic signed [bq_pkg::SAMPLE_BITS-1:0]   x_ff;
   logic                                    rsp_valid_ff;
   logic signed [bq_pkg::SAMPLE_BITS-1:0]   rsp_sample_ff;

   bq_pkg::mac_op_type                      mac_op;
   logic signed [bq_pkg::COEF_BITS-1:0]     mac_coef;
   logic signed [bq_pkg::STATE_BITS-1:0]    mac_data;
   logic signed [bq_pkg::ACC_BITS-1:0]      mac_init;
   logic signed [bq_pkg::ACC_BITS-1:0]      mac_acc;
   logic signed [bq_pkg::STATE_BITS-1:0]    w_sat;
   logic                                    req_take;
   logic                                    out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign w_sat     = bq_pkg::sat_state(mac_acc);

   // operand selection for the shared unit
   always_comb begin
      mac_op   = '0;
      mac_coef = coef_ff[bq_pkg::REG_A1];
      mac_data = delay_one_ff;
      mac_init = '0;
      unique case (state_ff)
         S_A1: begin
            mac_op   = '{issue: 1'b1, first: 1'b1, negate: 1'b1};
            mac_coef = coef_ff[bq_pkg::REG_A1];
            mac_data = delay_one_ff;
            mac_init = bq_pkg::ACC_BITS'(x_ff);
         end
         S_A2: begin
            mac_op   = '{issue: 1'b1, first: 1'b0, negate: 1'b1};
            mac_coef = coef_ff[bq_pkg::REG_A2];
            mac_data = delay_two_ff;
         end
         S_B0: begin
            mac_op   = '{issue: 1'b1, first: 1'b1, negate: 1'b0};
            mac_coef = coef_ff[bq_pkg::REG_B0];
            mac_data = w_sat;
         end
         S_B1: begin
            mac_op   = '{issue: 1'b1, first: 1'b0, negate: 1'b0};
            mac_coef = coef_ff[bq_pkg::REG_B1];
            mac_data = delay_one_ff;
         end
         S_B2: begin
            mac_op   = '{issue: 1'b1, first: 1'b0, negate: 1'b0};
            mac_coef = coef_ff[bq_pkg::REG_B2];
            mac_data = delay_two_ff;
         end
         default: begin
            mac_op = '0;
         end
      endcase
   end

   bq_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .coef  (mac_coef),
      .data  (mac_data),
      .init  (mac_init),
      .acc   (mac_acc)
   );

   // sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         delay_one_ff <= '0;
         delay_two_ff <= '0;
         for (int i = 0; i < bq_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else begin
         // coefficient writes
         if (csr_write_en) begin
            unique case (csr_index)
               bq_pkg::REG_B0: coef_ff[bq_pkg::REG_B0] <= csr_wdata;
               bq_pkg::REG_B1: coef_ff[bq_pkg::REG_B1] <= csr_wdata;
               bq_pkg::REG_B2: coef_ff[bq_pkg::REG_B2] <= csr_wdata;
               bq_pkg::REG_A1: coef_ff[bq_pkg::REG_A1] <= csr_wdata;
               bq_pkg::REG_A2: coef_ff[bq_pkg::REG_A2] <= csr_wdata;
               default: ;
            endcase
         end

         // response taken and no new one retiring
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  x_ff     <= req_sample_in;
                  state_ff <= S_A1;
               end
            end
            S_A1: state_ff <= S_A2;
            S_A2: state_ff <= S_W;
            S_W:  state_ff <= S_B0;
            S_B0: begin
               // accumulator now holds the feedback sum
               w_ff     <= w_sat;
               state_ff <= S_B1;
            end
            S_B1: state_ff <= S_B2;
            S_B2: state_ff <= S_Y;
            S_Y:  state_ff <= S_OUT;
            S_OUT: begin
               // wait for the output register, then retire the transaction
               if (out_free) begin
                  rsp_sample_ff <= bq_pkg::sat_sample(mac_acc);
                  rsp_valid_ff  <= 1'b1;
                  delay_two_ff  <= delay_one_ff;
                  delay_one_ff  <= w_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   // a response only appears when a transaction retires
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside retire step");

   // an accepted request starts the sequence
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == S_A1))
      else $error("accepted request did not start sequence");

   // retiring shifts the delay pair
   a_delay_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=>
         (delay_two_ff == $past(delay_one_ff) && delay_one_ff == $past(w_ff)))
      else $error("delay pair not shifted on retire");

   // a held response is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_sample_ff)))
      else $error("stalled response changed");

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for the direct form II biquad filter, with a
// predictor in fixed point, random valid/stall bursts and coefficient sweeps
// depends on bq_pkg and biquad_iir_filter
module tb_top;

   // coefficient values in Q3.28
   localparam logic [bq_pkg::COEF_BITS-1:0] Q_ZERO = 32'h0000_0000;
   localparam logic [bq_pkg::COEF_BITS-1:0] Q_ONE  = 32'h1000_0000;
   localparam logic [bq_pkg::COEF_BITS-1:0] Q_HALF = 32'h0800_0000;
   localparam logic [bq_pkg::COEF_BITS-1:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [bq_pkg::COEF_BITS-1:0] Q_MIN  = 32'h8000_0000;
   localparam logic [bq_pkg::COEF_BITS-1:0] Q_TINY = 32'h0008_0000;
   localparam int Q_SPAN  = 268435456;
   localparam int A2_SPAN = 241591910;

   localparam logic signed [bq_pkg::SAMPLE_BITS-1:0] S_MAX = 24'sh7F_FFFF;
   localparam logic signed [bq_pkg::SAMPLE_BITS-1:0] S_MIN = 24'sh80_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [bq_pkg::SAMPLE_BITS-1:0] req_sample_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [bq_pkg::SAMPLE_BITS-1:0] rsp_sample_out;
   logic csr_write_en = 1'b0;
   logic [bq_pkg::INDEX_BITS-1:0] csr_index = '0;
   logic [bq_pkg::COEF_BITS-1:0] csr_wdata = '0;

   // stimulus and scoreboard state
   logic signed [bq_pkg::SAMPLE_BITS-1:0] sample_queue[$];
   logic signed [bq_pkg::SAMPLE_BITS-1:0] expected_samples[$];
   logic signed [bq_pkg::COEF_BITS-1:0] coef_shadow[bq_pkg::NUM_COEFS];
   logic signed [bq_pkg::STATE_BITS-1:0] w_prev1;
   logic signed [bq_pkg::STATE_BITS-1:0] w_prev2;
   bit req_taken = 1'b0;
   bit idling = 1'b1;
   int req_gap = 0;
   int stall_left = 0;
   int fail_count = 0;

   biquad_iir_filter dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_sample_out(rsp_sample_out),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #5 clock = ~clock;

   // one product rounded half up at the coefficient fraction point
   function automatic longint round_mac(input logic signed [bq_pkg::COEF_BITS-1:0] c,
                                        input logic signed [bq_pkg::STATE_BITS-1:0] d);
      longint p;
      p = longint'(c) * longint'(d) + (longint'(1) << (bq_pkg::COEF_FRAC_BITS - 1));
      return p >>> bq_pkg::COEF_FRAC_BITS;
   endfunction

   function automatic longint clamp_signed(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -(longint'(1) << (bits - 1));
      if (v > hi) begin
         return hi;
      end
      if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

   // filter one sample and advance the delay pair
   function automatic logic signed [bq_pkg::SAMPLE_BITS-1:0] biquad_predict(
      input logic signed [bq_pkg::SAMPLE_BITS-1:0] x
   );
      longint w;
      longint y;
      w = longint'(x) - round_mac(coef_shadow[bq_pkg::REG_A1], w_prev1)
          - round_mac(coef_shadow[bq_pkg::REG_A2], w_prev2);
      w = clamp_signed(w, bq_pkg::STATE_BITS);
      y = round_mac(coef_shadow[bq_pkg::REG_B0], bq_pkg::STATE_BITS'(w))
          + round_mac(coef_shadow[bq_pkg::REG_B1], w_prev1)
          + round_mac(coef_shadow[bq_pkg::REG_B2], w_prev2);
      y = clamp_signed(y, bq_pkg::SAMPLE_BITS);
      w_prev2 = w_prev1;
      w_prev1 = bq_pkg::STATE_BITS'(w);
      return bq_pkg::SAMPLE_BITS'(y);
   endfunction

   function automatic logic [bq_pkg::COEF_BITS-1:0] small_coef();
      return bq_pkg::COEF_BITS'(longint'($urandom_range(0, 2 * Q_SPAN)) - Q_SPAN);
   endfunction

   function automatic logic [bq_pkg::COEF_BITS-1:0] extreme_coef();
      case ($urandom_range(0, 5))
         0: return Q_MIN;
         1: return Q_MAX;
         2: return Q_ZERO;
         3: return Q_ONE;
         4: return ~Q_ONE + 1'b1;
         default: return $urandom;
      endcase
   endfunction

   // request driver: new transaction or idle burst once the last one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (req_gap > 0) begin
            req_gap = req_gap - 1;
            req_valid <= 1'b0;
         end else if (idling && sample_queue.size() > 0 && $urandom_range(0, 4) == 0) begin
            req_gap = $urandom_range(0, 6);
            req_valid <= 1'b0;
         end else if (sample_queue.size() > 0) begin
            req_sample_in <= sample_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 6);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: mirror register writes, predict accepted samples, check responses
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bq_pkg::NUM_COEFS; k++) begin
            coef_shadow[k] = '0;
         end
         w_prev1 = '0;
         w_prev2 = '0;
      end else begin
         if (csr_write_en && csr_index < bq_pkg::NUM_COEFS) begin
            coef_shadow[csr_index] = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            expected_samples.push_back(biquad_predict(req_sample_in));
            req_taken = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("sample_out with no transaction pending: expected none, actual %0d",
                      rsp_sample_out);
               fail_count++;
            end else if (rsp_sample_out !== expected_samples[0]) begin
               $error("sample_out mismatch: expected %0d, actual %0d",
                      expected_samples[0], rsp_sample_out);
               fail_count++;
               void'(expected_samples.pop_front());
            end else begin
               void'(expected_samples.pop_front());
            end
         end
      end
   end

   task automatic csr_write(input logic [bq_pkg::INDEX_BITS-1:0] idx,
                            input logic [bq_pkg::COEF_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
   endtask

   task automatic load_coefs(input logic [bq_pkg::COEF_BITS-1:0] b0, b1, b2, a1, a2);
      csr_write(bq_pkg::REG_B0, b0);
      csr_write(bq_pkg::REG_B1, b1);
      csr_write(bq_pkg::REG_B2, b2);
      csr_write(bq_pkg::REG_A1, a1);
      csr_write(bq_pkg::REG_A2, a2);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // wait until every queued sample has gone through and the pipe is empty
   task automatic settle();
      do begin
         @(negedge clock);
      end while (sample_queue.size() != 0 || req_valid || expected_samples.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   // stimulus sequence
   initial begin
      int random_sent;
      int n;
      int mode;
      longint a1v;
      longint a2v;
      longint lim;
      logic signed [bq_pkg::SAMPLE_BITS-1:0] s;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // coefficients still at reset: output stays zero
      sample_queue.push_back(S_MAX);
      sample_queue.push_back(S_MIN);
      settle();

      // unity pass-through at the sample extremes
      load_coefs(Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      sample_queue.push_back(S_MIN);
      sample_queue.push_back(S_MAX);
      sample_queue.push_back('0);
      sample_queue.push_back(-24'sd1);
      sample_queue.push_back(24'sd1);
      settle();

      // half gain: rounding of exact halves in both signs
      load_coefs(Q_HALF, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      sample_queue.push_back(24'sd1);
      sample_queue.push_back(-24'sd1);
      sample_queue.push_back(24'sd3);
      sample_queue.push_back(-24'sd3);
      settle();

      // output saturation with the largest and smallest gains
      load_coefs(Q_MAX, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      sample_queue.push_back(S_MAX);
      sample_queue.push_back(S_MIN);
      settle();
      load_coefs(Q_MIN, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
      sample_queue.push_back(S_MAX);
      sample_queue.push_back(S_MIN);
      settle();

      // runaway feedback: internal value clamps high, then alternates
      load_coefs(Q_TINY, Q_ZERO, Q_ZERO, Q_MIN, Q_ZERO);
      repeat (4) sample_queue.push_back(S_MAX);
      settle();
      load_coefs(Q_TINY, Q_TINY, Q_TINY, Q_MAX, Q_ZERO);
      repeat (3) sample_queue.push_back(S_MIN);
      settle();

      // writes past the last register must leave the coefficients alone
      load_coefs(Q_HALF, Q_ONE, Q_MIN, Q_ZERO, Q_MAX);
      for (int k = bq_pkg::NUM_COEFS; k < 2 ** bq_pkg::INDEX_BITS; k++) begin
         csr_write(bq_pkg::INDEX_BITS'(k), 32'hFFFF_FFFF);
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      sample_queue.push_back(S_MAX);
      sample_queue.push_back(24'sh12_3456);
      sample_queue.push_back(S_MIN);
      settle();

      // random phases, each with its own coefficient set
      random_sent = 0;
      while (random_sent < 900) begin
         idling = (random_sent >= 800) ? 1'b0 : ($urandom_range(0, 3) != 0);
         mode = $urandom_range(0, 9);
         if (mode < 5) begin
            // stable second-order section
            a2v = longint'($urandom_range(0, 2 * A2_SPAN)) - A2_SPAN;
            lim = ((longint'(1) << bq_pkg::COEF_FRAC_BITS) + a2v) * 9 / 10;
            a1v = longint'($urandom_range(0, 32'(2 * lim))) - lim;
            load_coefs(small_coef(), small_coef(), small_coef(),
                       bq_pkg::COEF_BITS'(a1v), bq_pkg::COEF_BITS'(a2v));
         end else if (mode < 7) begin
            load_coefs(small_coef(), small_coef(), small_coef(), small_coef(),
                       small_coef());
         end else if (mode == 7) begin
            load_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            load_coefs(extreme_coef(), extreme_coef(), extreme_coef(), extreme_coef(),
                       extreme_coef());
         end
         n = (random_sent >= 800) ? 100 : $urandom_range(30, 90);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 3))
                     0: s = S_MAX;
                     1: s = S_MIN;
                     2: s = '0;
                     default: s = -24'sd1;
                  endcase
               end
               1, 2: s = bq_pkg::SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
               default: s = bq_pkg::SAMPLE_BITS'($urandom);
            endcase
            sample_queue.push_back(s);
         end
         random_sent += n;
         settle();
      end

      repeat (20) @(negedge clock);
      if (expected_samples.size() != 0) begin
         $error("sample_out missing: expected %0d more, actual 0", expected_samples.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
